// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== design/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// Types and constants shared by the length-prefixed message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmd_pkg;

  // Header geometry: count and length headers are 4 bytes, little-endian
  localparam int unsigned HdrBytes  = 4;
  localparam int unsigned HdrIdxW   = $clog2(HdrBytes);
  localparam int unsigned HdrShiftW = (HdrBytes - 1) * 8;
  localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrBytes - 1);

  // Limit register reset value
  localparam logic [31:0] MaxBytesReset = 32'hFFFF_FFFF;

  // Byte counter saturates at its all-ones value
  localparam int unsigned TotalW = 33;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA        = 2'd0,
    KIND_EMPTY_FRAME = 2'd1,
    KIND_EMPTY_MSG   = 2'd2,
    KIND_LEN_ERROR   = 2'd3
  } lpmd_kind_e;

  // Parser phases, one-hot
  typedef enum logic [2:0] {
    PH_COUNT   = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } lpmd_phase_e;

  // One result item
  typedef struct packed {
    lpmd_kind_e  kind;
    logic [7:0]  data_byte;
    logic [31:0] frame_number;
    logic        end_of_frame;
    logic        end_of_message;
  } lpmd_result_t;

endpackage

`default_nettype wire

// ===== design/lpmd_parser.sv =====
// ----------------------------------------------------------------------------
// lpmd_parser
// Message parsing state: header assembly, frame and payload counters and the
// size limit check. Produces at most one result per byte, combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmd_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,       // consume byte_i this cycle
  input  wire logic [7:0]          byte_i,
  input  wire logic [31:0]         max_bytes_i,
  output logic                     res_valid_o,
  output lpmd_pkg::lpmd_result_t   res_o
);

  lpmd_pkg::lpmd_phase_e                  phase_q, phase_d;
  logic [lpmd_pkg::HdrIdxW-1:0]           hdr_idx_q, hdr_idx_d;
  logic [lpmd_pkg::HdrShiftW-1:0]         hdr_shift_q, hdr_shift_d;
  logic [31:0]                            frames_rem_q, frames_rem_d;
  logic [31:0]                            cur_frame_q, cur_frame_d;
  logic [31:0]                            pay_rem_q, pay_rem_d;
  logic [lpmd_pkg::TotalW-1:0]            total_q, total_d;

  logic [lpmd_pkg::TotalW-1:0]            total_inc;
  logic [31:0]                            hdr_value;
  logic [31:0]                            frames_dec;
  logic [lpmd_pkg::TotalW:0]              size_sum;
  logic                                   over_limit;
  logic                                   hdr_done;
  logic                                   last_frame;

  // Saturating byte count including the current byte
  assign total_inc = (&total_q) ? total_q : total_q + lpmd_pkg::TotalW'(1);

  // Completed header value: three stored bytes plus the incoming top byte
  assign hdr_value = {byte_i, hdr_shift_q};
  assign hdr_done  = (hdr_idx_q == lpmd_pkg::HdrLastIdx);

  // Limit check: count so far plus announced length
  assign size_sum   = {1'b0, total_inc} + (lpmd_pkg::TotalW + 1)'(hdr_value);
  assign over_limit = size_sum > (lpmd_pkg::TotalW + 1)'(max_bytes_i);

  assign frames_dec = (frames_rem_q != '0) ? frames_rem_q - 32'd1 : '0;
  assign last_frame = (frames_rem_q == '0);

  // Next-state and result decode
  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    hdr_shift_d  = hdr_shift_q;
    frames_rem_d = frames_rem_q;
    cur_frame_d  = cur_frame_q;
    pay_rem_d    = pay_rem_q;
    total_d      = total_inc;
    res_valid_o  = 1'b0;
    res_o        = '{kind: lpmd_pkg::KIND_DATA, data_byte: '0, frame_number: '0,
                     end_of_frame: 1'b0, end_of_message: 1'b0};

    unique case (phase_q)
      lpmd_pkg::PH_PAYLOAD: begin
        res_valid_o           = 1'b1;
        res_o.data_byte       = byte_i;
        res_o.frame_number    = cur_frame_q;
        pay_rem_d             = pay_rem_q - 32'd1;
        if (pay_rem_q == 32'd1) begin
          res_o.end_of_frame   = 1'b1;
          res_o.end_of_message = last_frame;
          // frame done: next frame length or new message
          if (last_frame) begin
            phase_d      = lpmd_pkg::PH_COUNT;
            frames_rem_d = '0;
            cur_frame_d  = '0;
            pay_rem_d    = '0;
            total_d      = '0;
          end else begin
            phase_d     = lpmd_pkg::PH_LENGTH;
            cur_frame_d = cur_frame_q + 32'd1;
          end
          hdr_idx_d   = '0;
          hdr_shift_d = '0;
        end
      end

      lpmd_pkg::PH_LENGTH: begin
        if (!hdr_done) begin
          hdr_shift_d[hdr_idx_q*8 +: 8] = byte_i;
          hdr_idx_d = hdr_idx_q + lpmd_pkg::HdrIdxW'(1);
        end else begin
          hdr_idx_d   = '0;
          hdr_shift_d = '0;
          res_o.frame_number = cur_frame_q;
          if (over_limit) begin
            // size error ends the message
            res_valid_o          = 1'b1;
            res_o.kind           = lpmd_pkg::KIND_LEN_ERROR;
            res_o.end_of_message = 1'b1;
            phase_d      = lpmd_pkg::PH_COUNT;
            frames_rem_d = '0;
            cur_frame_d  = '0;
            pay_rem_d    = '0;
            total_d      = '0;
          end else if (hdr_value == '0) begin
            // empty frame marker
            res_valid_o          = 1'b1;
            res_o.kind           = lpmd_pkg::KIND_EMPTY_FRAME;
            res_o.end_of_frame   = 1'b1;
            res_o.end_of_message = (frames_dec == '0);
            if (frames_dec == '0) begin
              phase_d      = lpmd_pkg::PH_COUNT;
              frames_rem_d = '0;
              cur_frame_d  = '0;
              pay_rem_d    = '0;
              total_d      = '0;
            end else begin
              frames_rem_d = frames_dec;
              cur_frame_d  = cur_frame_q + 32'd1;
            end
          end else begin
            frames_rem_d = frames_dec;
            pay_rem_d    = hdr_value;
            phase_d      = lpmd_pkg::PH_PAYLOAD;
          end
        end
      end

      lpmd_pkg::PH_COUNT: begin
        if (!hdr_done) begin
          hdr_shift_d[hdr_idx_q*8 +: 8] = byte_i;
          hdr_idx_d = hdr_idx_q + lpmd_pkg::HdrIdxW'(1);
        end else begin
          hdr_idx_d   = '0;
          hdr_shift_d = '0;
          if (hdr_value == '0) begin
            // empty message marker
            res_valid_o          = 1'b1;
            res_o.kind           = lpmd_pkg::KIND_EMPTY_MSG;
            res_o.end_of_message = 1'b1;
            frames_rem_d = '0;
            cur_frame_d  = '0;
            pay_rem_d    = '0;
            total_d      = '0;
          end else begin
            frames_rem_d = hdr_value;
            cur_frame_d  = '0;
            phase_d      = lpmd_pkg::PH_LENGTH;
          end
        end
      end

      default: begin
        // unreachable code: restart on a clean message
        phase_d      = lpmd_pkg::PH_COUNT;
        hdr_idx_d    = '0;
        hdr_shift_d  = '0;
        frames_rem_d = '0;
        cur_frame_d  = '0;
        pay_rem_d    = '0;
        total_d      = '0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lpmd_pkg::PH_COUNT;
      hdr_idx_q    <= '0;
      hdr_shift_q  <= '0;
      frames_rem_q <= '0;
      cur_frame_q  <= '0;
      pay_rem_q    <= '0;
      total_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      hdr_shift_q  <= hdr_shift_d;
      frames_rem_q <= frames_rem_d;
      cur_frame_q  <= cur_frame_d;
      pay_rem_q    <= pay_rem_d;
      total_q      <= total_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/length_prefixed_message_deframer.sv =====
// Flow: a byte request accepted into the input register is parsed when the output
//   stage can advance, which loads its result into the output register.
// Throughput: one byte per cycle unless back-pressure stalls; the input and output
//   registers each advance whenever the downstream side is free or taking its request.
// Reset: asynchronous, active low; parser returns to reading a frame count and
//   the size limit returns to 0xFFFFFFFF.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream of count/length-prefixed messages into data bytes and
// marker results with frame index and end marks, enforcing a size limit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module length_prefixed_message_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // limit register write
  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,    // max_message_bytes

  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,     // [7:0] stream_byte

  // results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,     // [7:0] data_byte, [39:8] frame_number
  output logic             m_axis_tlast,     // end_of_frame
  output logic [2:0]       m_axis_tuser      // [1:0] kind, [2] end_of_message
);

  logic [31:0]            max_bytes_q;
  logic                   in_valid_q, in_valid_d;
  logic [7:0]             in_byte_q;
  logic                   out_valid_q, out_valid_d;
  lpmd_pkg::lpmd_result_t out_q;

  logic                   advance;
  logic                   step;
  logic                   res_valid;
  lpmd_pkg::lpmd_result_t res;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= lpmd_pkg::MaxBytesReset;
    end else if (cfg_wr_en_i) begin
      max_bytes_q <= cfg_wr_data_i;
    end
  end

  // Pipeline flow: output stage free or draining lets the input stage move
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  assign in_valid_d  = (s_axis_tvalid && s_axis_tready) ? 1'b1 :
                       (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? (step && res_valid) : out_valid_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  lpmd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .max_bytes_i (max_bytes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_number, out_q.data_byte};
  assign m_axis_tlast  = out_q.end_of_frame;
  assign m_axis_tuser  = {out_q.end_of_message, out_q.kind};

  // Checks
  `ASSERT_IMPLY(a_marker_no_data, clk_i, rst_ni,
    m_axis_tvalid && (out_q.kind != lpmd_pkg::KIND_DATA), out_q.data_byte == 8'd0)
  `ASSERT_IMPLY(a_error_ends_msg, clk_i, rst_ni,
    m_axis_tvalid && (out_q.kind == lpmd_pkg::KIND_LEN_ERROR),
    out_q.end_of_message && !out_q.end_of_frame)
  `ASSERT_IMPLY(a_empty_msg_frame0, clk_i, rst_ni,
    m_axis_tvalid && (out_q.kind == lpmd_pkg::KIND_EMPTY_MSG),
    (out_q.frame_number == 32'd0) && out_q.end_of_message)
  `ASSERT_NEXT(a_result_lands, clk_i, rst_ni, step && res_valid, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds count/length-prefixed byte messages into the deframer and checks every
// result against an in-bench parser model or a hand-written expectation, under
// several size limits and with random gaps on the input and output sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned CfgSettle = 8;
  localparam lpmd_pkg::lpmd_result_t NoResult = '0;

  // Directed byte with an optional hand-written expectation
  typedef struct packed {
    logic [7:0]             stream_byte;
    logic                   typed;
    lpmd_pkg::lpmd_result_t result;
  } scripted_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [31:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  // Parser model state
  lpmd_pkg::lpmd_phase_e ph;
  logic [1:0]  hdr_idx;
  logic [31:0] hdr_acc;
  logic [31:0] frames_left;
  logic [31:0] frame_idx;
  logic [31:0] payload_left;
  logic [32:0] byte_total;
  logic [31:0] limit;

  lpmd_pkg::lpmd_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  send_gap_pct = 33;
  int unsigned  recv_gap_pct = 64;
  int unsigned  stall_cycles = 0;

  // Empty message, two frames (one byte, then empty), oversize length
  scripted_byte_t scripted [25] = '{
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b1, '{lpmd_pkg::KIND_EMPTY_MSG, 8'h00, 32'd0, 1'b0, 1'b1}},
    '{8'h02, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'h01, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'hFF, 1'b1, '{lpmd_pkg::KIND_DATA, 8'hFF, 32'd0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b1, '{lpmd_pkg::KIND_EMPTY_FRAME, 8'h00, 32'd1, 1'b1, 1'b1}},
    '{8'h01, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult},
    '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult},
    '{8'hFF, 1'b1, '{lpmd_pkg::KIND_LEN_ERROR, 8'h00, 32'd0, 1'b0, 1'b1}}
  };

  length_prefixed_message_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_message();
    ph = lpmd_pkg::PH_COUNT;
    hdr_idx = '0;
    hdr_acc = '0;
    frames_left = '0;
    frame_idx = '0;
    payload_left = '0;
    byte_total = '0;
  endfunction

  // End of a frame: next length header, or back to a new message
  function automatic void close_frame();
    if (frames_left == 0) begin
      restart_message();
    end else begin
      frame_idx++;
      ph = lpmd_pkg::PH_LENGTH;
      hdr_idx = '0;
      hdr_acc = '0;
    end
  endfunction

  // Advance the parser model by one byte; returns 1 if a result comes out
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output lpmd_pkg::lpmd_result_t res);
    logic [31:0] hdr_val;
    logic        eof;
    res = NoResult;
    if (byte_total != '1) byte_total = byte_total + 33'd1;
    if (ph == lpmd_pkg::PH_PAYLOAD) begin
      payload_left--;
      eof = (payload_left == 0);
      res = '{lpmd_pkg::KIND_DATA, b, frame_idx, eof, eof && (frames_left == 0)};
      if (eof) close_frame();
      return 1'b1;
    end
    hdr_acc |= 32'(b) << (8 * hdr_idx);
    hdr_idx++;
    if (hdr_idx != 0) return 1'b0;
    hdr_val = hdr_acc;
    hdr_acc = '0;
    if (ph == lpmd_pkg::PH_LENGTH) begin
      // limit check covers empty frames as well
      if (34'(byte_total) + 34'(hdr_val) > 34'(limit)) begin
        res = '{lpmd_pkg::KIND_LEN_ERROR, 8'h00, frame_idx, 1'b0, 1'b1};
        restart_message();
        return 1'b1;
      end
      if (frames_left > 0) frames_left--;
      if (hdr_val == 0) begin
        res = '{lpmd_pkg::KIND_EMPTY_FRAME, 8'h00, frame_idx, 1'b1, frames_left == 0};
        close_frame();
        return 1'b1;
      end
      payload_left = hdr_val;
      ph = lpmd_pkg::PH_PAYLOAD;
      return 1'b0;
    end
    // frame count header done
    if (hdr_val == 0) begin
      res = '{lpmd_pkg::KIND_EMPTY_MSG, 8'h00, 32'd0, 1'b0, 1'b1};
      restart_message();
      return 1'b1;
    end
    frames_left = hdr_val;
    frame_idx = '0;
    ph = lpmd_pkg::PH_LENGTH;
    return 1'b0;
  endfunction

  // Send one byte request; the model advances once it is accepted
  task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input lpmd_pkg::lpmd_result_t typed_res = NoResult);
    lpmd_pkg::lpmd_result_t predicted;
    bit                     produced;
    if (bytes_sent < 185) begin
      send_gap_pct = 33;
      recv_gap_pct = 64;
    end else if (bytes_sent < 370) begin
      send_gap_pct = 64;
      recv_gap_pct = 33;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    if ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    produced = deframe_byte(b, predicted);
    if (typed) pending_results = {pending_results, typed_res};
    else if (produced) pending_results = {pending_results, predicted};
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  // Frame length: at times near the limit edge or random when the limit is tight, else short or zero
  function automatic logic [31:0] pick_length();
    logic [33:0] room;
    room = 34'(limit) - 34'(byte_total) - 34'd4;
    if (limit < 4096 && $urandom_range(3) == 0) begin
      if (room[33]) return $urandom;
      // keep edge-hitting payloads short
      if (room < 34'd128) return room[31:0] + $urandom_range(1);
    end
    if (limit < 4096 && $urandom_range(7) == 0) return $urandom;
    if ($urandom_range(5) == 0) return '0;
    if ($urandom_range(9) == 0) return $urandom_range(24, 7);
    return $urandom_range(6, 1);
  endfunction

  // One message; a few are cut short by an oversize length
  task automatic send_message();
    logic [31:0] frame_count;
    int unsigned planned;
    bit          broken;
    broken = 1'b0;
    if ($urandom_range(11) == 0) begin
      frame_count = '0;
    end else if ($urandom_range(14) == 0) begin
      frame_count = $urandom | 32'h100;
      broken = 1'b1;
    end else begin
      frame_count = $urandom_range(4, 1);
    end
    planned = broken ? $urandom_range(2) : int'(frame_count);
    send_word(frame_count);
    for (int f = 0; f < planned && ph == lpmd_pkg::PH_LENGTH; f++) begin
      send_word(pick_length());
      while (ph == lpmd_pkg::PH_PAYLOAD) push_byte($urandom);
    end
    if (broken && ph == lpmd_pkg::PH_LENGTH) send_word(32'hFFFF_FFFF);
  endtask

  // Messages, plus raw bursts when noise is allowed (tight limit only)
  task automatic run_messages(input int unsigned budget, input bit with_noise);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (with_noise && $urandom_range(3) == 0) begin
        repeat ($urandom_range(8, 1)) push_byte($urandom);
      end else begin
        send_message();
      end
    end
  endtask

  // Limit write once the block has drained
  task automatic write_limit(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    limit = value;
  endtask

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    lpmd_pkg::lpmd_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: tdata 0x%0h tuser 0x%0h",
               m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tuser[1:0]));
        check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
        check_field("frame_number", want.frame_number, m_axis_tdata[39:8]);
        check_field("end_of_frame", 32'(want.end_of_frame), 32'(m_axis_tlast));
        check_field("end_of_message", 32'(want.end_of_message), 32'(m_axis_tuser[2]));
      end
    end
  end

  // Watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("[length_prefixed_message_deframer] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    limit = lpmd_pkg::MaxBytesReset;
    restart_message();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (scripted[i]) push_byte(scripted[i].stream_byte, scripted[i].typed,
                                    scripted[i].result);
    run_messages(100, 1'b0);

    write_limit('0);
    run_messages(40, 1'b1);

    write_limit($urandom_range(120, 30));
    run_messages(100, 1'b1);

    // this change may land mid-message
    write_limit($urandom_range(120, 30));
    run_messages(80, 1'b1);
    while (!(ph == lpmd_pkg::PH_COUNT && hdr_idx == 0)) begin
      push_byte(ph == lpmd_pkg::PH_LENGTH ? 8'hFF : 8'($urandom));
    end

    write_limit(32'hFFFF_FFFF);
    run_messages(100, 1'b0);

    write_limit($urandom_range(2000, 200));
    run_messages(70, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[length_prefixed_message_deframer] OK");
    end else begin
      $display("[length_prefixed_message_deframer] ERROR");
    end
    $finish;
  end

endmodule
